[rtl/core/dbpc_pkg.sv]
// Shared types, constants and evaluation functions for the dual bridge power coordinator.
`timescale 1ns / 1ps

package dbpc_pkg;

    localparam int RECEIVER_COUNT = 8;
    localparam int MAX_WRITES     = 4;

    typedef enum logic [2:0] {
        CMD_ACQ_RCV  = 3'd0,
        CMD_REL_RCV  = 3'd1,
        CMD_ACQ_CARD = 3'd2,
        CMD_REL_CARD = 3'd3,
        CMD_RECON    = 3'd4,
        CMD_DISCON   = 3'd5,
        CMD_SNAP     = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        BS_OFF     = 2'd0,
        BS_ON      = 2'd1,
        BS_UNKNOWN = 2'd2,
        BS_DISC    = 2'd3
    } t_bstate;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DISC  = 3'd1,
        ST_INVAL = 3'd2,
        ST_BUSY  = 3'd3,
        ST_FAIL  = 3'd4
    } t_status;

    localparam logic [1:0] OC_OK   = 2'd0;
    localparam logic [1:0] OC_DISC = 2'd1;

    typedef struct packed {
        logic bridge;
        logic on;
    } t_wr;

    typedef struct packed {
        t_bstate nxt;
        t_status st;
        logic    wrote;
    } t_drive;

    typedef struct packed {
        t_bstate        bs0;
        t_bstate        bs1;
        t_status        st;
        logic [1:0]     nw;
        t_wr [1:0]      w;
    } t_pass;

    typedef struct packed {
        logic [2:0]     wcnt;
        t_wr [3:0]      w;
        t_status        st;
        logic [7:0]     mask;
        logic           card;
        t_bstate        bs0;
        t_bstate        bs1;
    } t_bundle;

    function automatic t_drive drive_bridge(input t_bstate cur, input logic on,
                                            input logic [1:0] oc);
        t_drive d;
        d.nxt   = cur;
        d.st    = ST_OK;
        d.wrote = 1'b0;
        if (cur == BS_DISC) begin
            d.st = on ? ST_DISC : ST_OK;
        end else if ((on && cur == BS_ON) || (!on && cur == BS_OFF)) begin
            d.st = ST_OK;
        end else begin
            d.wrote = 1'b1;
            if (oc == OC_OK) begin
                d.nxt = on ? BS_ON : BS_OFF;
                d.st  = ST_OK;
            end else if (oc == OC_DISC) begin
                d.nxt = BS_DISC;
                d.st  = ST_DISC;
            end else begin
                d.nxt = BS_UNKNOWN;
                d.st  = ST_FAIL;
            end
        end
        return d;
    endfunction

    function automatic t_pass apply_pass(input logic [7:0] mask, input logic card,
                                         input t_bstate bs0, input t_bstate bs1,
                                         input logic [3:0][1:0] oc,
                                         input logic [1:0] base);
        t_pass      p;
        t_drive     d0;
        t_drive     d1;
        logic       on0;
        logic       on1;
        logic [1:0] i1;
        on0 = (|mask) | card;
        on1 = |mask;
        d0  = drive_bridge(bs0, on0, oc[base]);
        i1  = base + {1'b0, d0.wrote};
        d1  = drive_bridge(bs1, on1, oc[i1]);
        p.bs0         = d0.nxt;
        p.w[1].bridge = 1'b1;
        p.w[1].on     = on1;
        if (d0.st != ST_OK) begin
            p.bs1         = bs1;
            p.st          = d0.st;
            p.nw          = {1'b0, d0.wrote};
            p.w[0].bridge = 1'b0;
            p.w[0].on     = on0;
        end else begin
            p.bs1         = d1.nxt;
            p.st          = d1.st;
            p.nw          = {1'b0, d0.wrote} + {1'b0, d1.wrote};
            p.w[0].bridge = !d0.wrote;
            p.w[0].on     = d0.wrote ? on0 : on1;
        end
        return p;
    endfunction

endpackage

[rtl/core/dbpc_eval.sv]
// Combinational evaluation of one command against the current hold and bridge state.
`timescale 1ns / 1ps

module dbpc_eval (
    input  logic [2:0]               i_command,
    input  logic [7:0]               i_receiver_id,
    input  logic                     i_bridge,
    input  logic [3:0][1:0]          i_outcomes,
    input  logic [7:0]               i_mask,
    input  logic                     i_card,
    input  dbpc_pkg::t_bstate        i_bs0,
    input  dbpc_pkg::t_bstate        i_bs1,
    output dbpc_pkg::t_bundle        o_bundle
);

    logic [7:0]          bit_sel;
    logic                any_disc;
    logic [7:0]          cand_mask;
    logic                cand_card;
    logic                use_pass;
    logic                is_acq;
    dbpc_pkg::t_pass     p1;
    dbpc_pkg::t_pass     p2;
    logic [1:0]          j_idx;

    assign bit_sel  = (i_receiver_id < 8'(dbpc_pkg::RECEIVER_COUNT))
                      ? (8'b1 << i_receiver_id[2:0]) : 8'b0;
    assign any_disc = (i_bs0 == dbpc_pkg::BS_DISC) || (i_bs1 == dbpc_pkg::BS_DISC);

    always_comb begin
        o_bundle      = '0;
        o_bundle.mask = i_mask;
        o_bundle.card = i_card;
        o_bundle.bs0  = i_bs0;
        o_bundle.bs1  = i_bs1;
        o_bundle.st   = dbpc_pkg::ST_OK;
        cand_mask     = i_mask;
        cand_card     = i_card;
        use_pass      = 1'b0;
        is_acq        = 1'b0;
        j_idx         = '0;
        case (dbpc_pkg::t_cmd'(i_command))
            dbpc_pkg::CMD_ACQ_RCV: begin
                if (any_disc) begin
                    o_bundle.st = dbpc_pkg::ST_DISC;
                end else if (bit_sel == 8'b0) begin
                    o_bundle.st = dbpc_pkg::ST_INVAL;
                end else if (|(i_mask & bit_sel)) begin
                    o_bundle.st = dbpc_pkg::ST_BUSY;
                end else begin
                    cand_mask = i_mask | bit_sel;
                    use_pass  = 1'b1;
                    is_acq    = 1'b1;
                end
            end
            dbpc_pkg::CMD_REL_RCV: begin
                if (bit_sel == 8'b0 || !(|(i_mask & bit_sel))) begin
                    o_bundle.st = dbpc_pkg::ST_INVAL;
                end else begin
                    cand_mask = i_mask & ~bit_sel;
                    use_pass  = 1'b1;
                end
            end
            dbpc_pkg::CMD_ACQ_CARD: begin
                if (any_disc) begin
                    o_bundle.st = dbpc_pkg::ST_DISC;
                end else if (i_card) begin
                    o_bundle.st = dbpc_pkg::ST_BUSY;
                end else begin
                    cand_card = 1'b1;
                    use_pass  = 1'b1;
                    is_acq    = 1'b1;
                end
            end
            dbpc_pkg::CMD_REL_CARD: begin
                if (!i_card) begin
                    o_bundle.st = dbpc_pkg::ST_INVAL;
                end else begin
                    cand_card = 1'b0;
                    use_pass  = 1'b1;
                end
            end
            dbpc_pkg::CMD_RECON: begin
                if (any_disc) begin
                    o_bundle.st = dbpc_pkg::ST_DISC;
                end else begin
                    use_pass = 1'b1;
                end
            end
            dbpc_pkg::CMD_DISCON: begin
                o_bundle.mask = 8'b0;
                o_bundle.card = 1'b0;
                if (i_bridge) begin
                    o_bundle.bs1 = dbpc_pkg::BS_DISC;
                    if (i_bs0 == dbpc_pkg::BS_ON) begin
                        o_bundle.bs0 = dbpc_pkg::BS_UNKNOWN;
                    end
                end else begin
                    o_bundle.bs0 = dbpc_pkg::BS_DISC;
                    if (i_bs1 == dbpc_pkg::BS_ON) begin
                        o_bundle.bs1 = dbpc_pkg::BS_UNKNOWN;
                    end
                end
            end
            dbpc_pkg::CMD_SNAP: begin
                o_bundle.st = dbpc_pkg::ST_OK;
            end
            default: begin
                o_bundle.st = dbpc_pkg::ST_INVAL;
            end
        endcase

        p1 = dbpc_pkg::apply_pass(cand_mask, cand_card, i_bs0, i_bs1, i_outcomes, 2'd0);
        p2 = dbpc_pkg::apply_pass(i_mask, i_card, p1.bs0, p1.bs1, i_outcomes, p1.nw);

        if (use_pass) begin
            o_bundle.st = p1.st;
            for (int i = 0; i < dbpc_pkg::MAX_WRITES; i++) begin
                j_idx = 2'(i) - p1.nw;
                if (2'(i) < p1.nw) begin
                    o_bundle.w[i] = p1.w[1'(i)];
                end else begin
                    o_bundle.w[i] = p2.w[j_idx[0]];
                end
            end
            if (is_acq && p1.st != dbpc_pkg::ST_OK) begin
                o_bundle.mask = i_mask;
                o_bundle.card = i_card;
                o_bundle.bs0  = p2.bs0;
                o_bundle.bs1  = p2.bs1;
                o_bundle.wcnt = {1'b0, p1.nw} + {1'b0, p2.nw};
            end else begin
                o_bundle.mask = cand_mask;
                o_bundle.card = cand_card;
                o_bundle.bs0  = p1.bs0;
                o_bundle.bs1  = p1.bs1;
                o_bundle.wcnt = {1'b0, p1.nw};
            end
        end
    end

endmodule

[rtl/core/dbpc_emit.sv]
// Result register that holds one evaluated command and sends its write and status transactions.
`timescale 1ns / 1ps

module dbpc_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  dbpc_pkg::t_bundle    i_bundle,
    output logic                 o_free,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_is_write,
    output logic                 o_write_bridge,
    output logic                 o_write_on,
    output logic [2:0]           o_status,
    output logic                 o_last,
    output logic [7:0]           o_held_receivers,
    output logic                 o_card_held_now,
    output logic [1:0]           o_first_bridge_state,
    output logic [1:0]           o_second_bridge_state
);

    dbpc_pkg::t_bundle r_bundle;
    logic              r_busy;
    logic              n_busy;
    logic [2:0]        r_idx;
    logic [2:0]        n_idx;
    logic              is_wr;
    logic              take;
    logic              done;
    dbpc_pkg::t_wr     cur_wr;

    assign is_wr  = r_idx < r_bundle.wcnt;
    assign cur_wr = r_bundle.w[r_idx[1:0]];
    assign take   = r_busy && !i_out_stall;
    assign done   = take && !is_wr;
    assign o_free = !r_busy || done;

    assign o_out_valid           = r_busy;
    assign o_is_write            = is_wr;
    assign o_write_bridge        = is_wr ? cur_wr.bridge : 1'b0;
    assign o_write_on            = is_wr ? cur_wr.on : 1'b0;
    assign o_status              = is_wr ? 3'b0 : r_bundle.st;
    assign o_last                = !is_wr;
    assign o_held_receivers      = is_wr ? 8'b0 : r_bundle.mask;
    assign o_card_held_now       = is_wr ? 1'b0 : r_bundle.card;
    assign o_first_bridge_state  = is_wr ? 2'b0 : r_bundle.bs0;
    assign o_second_bridge_state = is_wr ? 2'b0 : r_bundle.bs1;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (i_load) begin
            n_busy = 1'b1;
            n_idx  = 3'd0;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (take) begin
            n_idx = r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_bundle.wcnt))
        else $error("Result index ran past the status transaction.");

    a_wcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_bundle.wcnt <= 3'(dbpc_pkg::MAX_WRITES)))
        else $error("Too many power writes held for one command.");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_out_stall) |=> (r_busy && $stable(r_idx)))
        else $error("Pending transaction moved while the receiver stalled.");

    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !i_load) |=> !r_busy)
        else $error("Result register stayed busy after the status transaction.");

endmodule

[rtl/core/dual_bridge_power_coordinator.sv]
// Top level of the dual bridge power coordinator: command register, state and result stage.
//
// One command enters on the input channel (i_in_valid, o_in_stall) as a transaction with
// its receiver number, bridge and the outcomes of up to four power writes. Each command
// produces zero to four power write transactions on the output channel (o_out_valid,
// i_out_stall), bridge 0 before bridge 1 in each pass, then one status transaction with
// o_last high that carries the hold mask, card flag and both bridge states.
// A command is captured in the input register, evaluated combinationally from it and
// loaded into the result register once that register is free, from which its first
// result is offered. The result register sends one transaction per cycle while the
// receiver does not stall. A new command is taken into the input register while the
// previous one is still being sent.
// When the receiver stalls, the current transaction holds and the input register
// fills, after which o_in_stall rises until the result register frees up.
// Synchronous reset clears all holds, marks both bridges unknown and drops any
// pending command or result.
`timescale 1ns / 1ps

module dual_bridge_power_coordinator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_receiver_id,
    input  logic        i_bridge,
    input  logic [1:0]  i_outcome_first,
    input  logic [1:0]  i_outcome_second,
    input  logic [1:0]  i_outcome_third,
    input  logic [1:0]  i_outcome_fourth,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_write,
    output logic        o_write_bridge,
    output logic        o_write_on,
    output logic [2:0]  o_status,
    output logic        o_last,
    output logic [7:0]  o_held_receivers,
    output logic        o_card_held_now,
    output logic [1:0]  o_first_bridge_state,
    output logic [1:0]  o_second_bridge_state
);

    logic               r_in_valid;
    logic               n_in_valid;
    logic [2:0]         r_command;
    logic [7:0]         r_receiver_id;
    logic               r_bridge;
    logic [3:0][1:0]    r_outcomes;
    logic [7:0]         r_mask;
    logic               r_card;
    dbpc_pkg::t_bstate  r_bs0;
    dbpc_pkg::t_bstate  r_bs1;
    logic               in_take;
    logic               load;
    logic               emit_free;
    dbpc_pkg::t_bundle  bundle;

    assign load       = r_in_valid && emit_free;
    assign o_in_stall = r_in_valid && !emit_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (load) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mask     <= 8'b0;
            r_card     <= 1'b0;
            r_bs0      <= dbpc_pkg::BS_UNKNOWN;
            r_bs1      <= dbpc_pkg::BS_UNKNOWN;
        end else begin
            r_in_valid <= n_in_valid;
            if (load) begin
                r_mask <= bundle.mask;
                r_card <= bundle.card;
                r_bs0  <= bundle.bs0;
                r_bs1  <= bundle.bs1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command     <= i_command;
            r_receiver_id <= i_receiver_id;
            r_bridge      <= i_bridge;
            r_outcomes    <= {i_outcome_fourth, i_outcome_third,
                              i_outcome_second, i_outcome_first};
        end
    end

    dbpc_eval u_eval (
        .i_command     (r_command),
        .i_receiver_id (r_receiver_id),
        .i_bridge      (r_bridge),
        .i_outcomes    (r_outcomes),
        .i_mask        (r_mask),
        .i_card        (r_card),
        .i_bs0         (r_bs0),
        .i_bs1         (r_bs1),
        .o_bundle      (bundle)
    );

    dbpc_emit u_emit (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_load                (load),
        .i_bundle              (bundle),
        .o_free                (emit_free),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_is_write            (o_is_write),
        .o_write_bridge        (o_write_bridge),
        .o_write_on            (o_write_on),
        .o_status              (o_status),
        .o_last                (o_last),
        .o_held_receivers      (o_held_receivers),
        .o_card_held_now       (o_card_held_now),
        .o_first_bridge_state  (o_first_bridge_state),
        .o_second_bridge_state (o_second_bridge_state)
    );

endmodule
